[src/mggeb_pkg.sv]
// Shared constants, types and helpers for the masked grid graph edge builder.
package mggeb_pkg;

    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 256;

    localparam int SIZE_W      = 9;
    localparam int DIM_W       = 13;
    localparam int X_W         = $clog2(MAX_X);
    localparam int Y_W         = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int Z_W         = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int PLANE_DEPTH = MAX_X * MAX_Y;
    localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
    localparam int NODE_W      = 24;
    localparam int NODE_CNT_W  = 25;
    localparam int VOX_W       = 24;
    localparam int ENTRY_W     = NODE_W + 1;
    localparam int QDEPTH      = 4;
    localparam int Q_AW        = $clog2(QDEPTH);
    localparam int Q_CW        = $clog2(QDEPTH + 1);
    localparam int SUB_W       = 2;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_NODE = 1'b0,
        KIND_EDGE = 1'b1
    } kind_t;

    // One set voxel with its neighbors already packed in emit order.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [VOX_W-1:0]  vidx;
        logic [NODE_W-1:0] nb0;
        logic [NODE_W-1:0] nb1;
        logic [NODE_W-1:0] nb2;
        logic [SUB_W-1:0]  edges;
    } item_t;

    typedef struct packed {
        logic            empty;
        logic [Q_CW-1:0] count;
    } queue_status_t;

    function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [DIM_W-1:0] bound);
        logic [DIM_W-1:0] vext;
        vext = DIM_W'(v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        if (vext > bound)
        begin
            return bound;
        end
        return vext;
    endfunction

endpackage

[src/mggeb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mggeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mggeb_front.sv]
// Front end: voxel intake, position tracking, plane store lookup and neighbor packing.
module mggeb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mask_valid,
    output logic                          mask_stall,
    input  logic                          mask_bit,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mggeb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mggeb_pkg::SIZE_W-1:0]  cfg_data,
    input  mggeb_pkg::queue_status_t      q_status,
    output logic                          push,
    output mggeb_pkg::item_t              push_item
);

    logic [mggeb_pkg::SIZE_W-1:0]     size_x_reg, size_y_reg, size_z_reg;
    logic [mggeb_pkg::X_W-1:0]        pos_x_reg, pos_x_next;
    logic [mggeb_pkg::Y_W-1:0]        pos_y_reg, pos_y_next;
    logic [mggeb_pkg::Z_W-1:0]        pos_z_reg, pos_z_next;
    logic [mggeb_pkg::VOX_W-1:0]      vox_cnt_reg, vox_cnt_next;
    logic [mggeb_pkg::NODE_CNT_W-1:0] node_cnt_reg, node_cnt_next;
    logic                             prev_set_reg;
    logic [mggeb_pkg::NODE_W-1:0]     prev_node_reg;

    logic                             s1_valid_reg;
    logic                             s1_set_reg;
    logic [mggeb_pkg::NODE_W-1:0]     s1_node_reg;
    logic [mggeb_pkg::VOX_W-1:0]      s1_vidx_reg;
    logic                             s1_xhit_reg;
    logic [mggeb_pkg::NODE_W-1:0]     s1_xnode_reg;
    logic                             s1_ychk_reg;
    logic                             s1_zchk_reg;

    logic [mggeb_pkg::DIM_W-1:0]      sx, sy, sz;
    logic [mggeb_pkg::Q_CW:0]         occupancy;
    logic                             accept;
    logic [mggeb_pkg::NODE_W-1:0]     me;
    logic [mggeb_pkg::PLANE_AW-1:0]   here_addr, up_addr;
    logic [mggeb_pkg::ENTRY_W-1:0]    wdata;
    logic [mggeb_pkg::ENTRY_W-1:0]    ydata, zdata;
    logic                             x_end, y_end, z_end;
    logic                             fx, fy, fz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= mggeb_pkg::SIZE_W'(256);
            size_y_reg <= mggeb_pkg::SIZE_W'(256);
            size_z_reg <= mggeb_pkg::SIZE_W'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mggeb_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                mggeb_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                mggeb_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sx = mggeb_pkg::clamp_size(size_x_reg, mggeb_pkg::DIM_W'(mggeb_pkg::MAX_X));
    assign sy = mggeb_pkg::clamp_size(size_y_reg, mggeb_pkg::DIM_W'(mggeb_pkg::MAX_Y));
    assign sz = mggeb_pkg::clamp_size(size_z_reg, mggeb_pkg::DIM_W'(mggeb_pkg::MAX_Z));

    // The voxel in the lookup stage lands in the queue next cycle if it is set, so it
    // holds a slot already.
    assign occupancy  = {1'b0, q_status.count} + {{mggeb_pkg::Q_CW{1'b0}}, s1_valid_reg};
    assign mask_stall = occupancy >= (mggeb_pkg::Q_CW + 1)'(mggeb_pkg::QDEPTH);
    assign accept     = mask_valid && !mask_stall;

    assign me        = node_cnt_reg[mggeb_pkg::NODE_W-1:0];
    assign here_addr = mggeb_pkg::PLANE_AW'(int'(pos_y_reg) * mggeb_pkg::MAX_X
                                            + int'(pos_x_reg));
    assign up_addr   = (pos_y_reg != '0)
                     ? mggeb_pkg::PLANE_AW'(int'(pos_y_reg - mggeb_pkg::Y_W'(1))
                                            * mggeb_pkg::MAX_X + int'(pos_x_reg))
                     : here_addr;
    assign wdata     = mask_bit ? {1'b1, me} : '0;

    // Two copies of the plane store, one per lookup address; both take the same writes.
    mggeb_ram #(
        .WIDTH (mggeb_pkg::ENTRY_W),
        .DEPTH (mggeb_pkg::PLANE_DEPTH)
    ) u_plane_up (
        .clk   (clk),
        .we    (accept),
        .waddr (here_addr),
        .wdata (wdata),
        .re    (accept),
        .raddr (up_addr),
        .rdata (ydata)
    );

    mggeb_ram #(
        .WIDTH (mggeb_pkg::ENTRY_W),
        .DEPTH (mggeb_pkg::PLANE_DEPTH)
    ) u_plane_here (
        .clk   (clk),
        .we    (accept),
        .waddr (here_addr),
        .wdata (wdata),
        .re    (accept),
        .raddr (here_addr),
        .rdata (zdata)
    );

    always_comb
    begin
        x_end         = (mggeb_pkg::DIM_W'(pos_x_reg) + mggeb_pkg::DIM_W'(1)) >= sx;
        y_end         = (mggeb_pkg::DIM_W'(pos_y_reg) + mggeb_pkg::DIM_W'(1)) >= sy;
        z_end         = (mggeb_pkg::DIM_W'(pos_z_reg) + mggeb_pkg::DIM_W'(1)) >= sz;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        vox_cnt_next  = vox_cnt_reg;
        node_cnt_next = node_cnt_reg;
        if (accept)
        begin
            vox_cnt_next = vox_cnt_reg + mggeb_pkg::VOX_W'(1);
            if (mask_bit)
            begin
                node_cnt_next = node_cnt_reg + mggeb_pkg::NODE_CNT_W'(1);
            end
            if (!x_end)
            begin
                pos_x_next = pos_x_reg + mggeb_pkg::X_W'(1);
            end
            else
            begin
                pos_x_next = '0;
                if (!y_end)
                begin
                    pos_y_next = pos_y_reg + mggeb_pkg::Y_W'(1);
                end
                else
                begin
                    pos_y_next = '0;
                    if (!z_end)
                    begin
                        pos_z_next = pos_z_reg + mggeb_pkg::Z_W'(1);
                    end
                    else
                    begin
                        pos_z_next    = '0;
                        vox_cnt_next  = '0;
                        node_cnt_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            vox_cnt_reg  <= '0;
            node_cnt_reg <= '0;
            prev_set_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            vox_cnt_reg  <= vox_cnt_next;
            node_cnt_reg <= node_cnt_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                prev_set_reg <= mask_bit;
            end
        end
    end

    // Any voxel with x above zero directly follows its x-1 neighbor, so that
    // neighbor is simply the previous voxel.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_node_reg <= me;
            s1_set_reg    <= mask_bit;
            s1_node_reg   <= me;
            s1_vidx_reg   <= vox_cnt_reg;
            s1_xhit_reg   <= (pos_x_reg != '0) && prev_set_reg;
            s1_xnode_reg  <= prev_node_reg;
            s1_ychk_reg   <= pos_y_reg != '0;
            s1_zchk_reg   <= pos_z_reg != '0;
        end
    end

    assign fx = s1_xhit_reg;
    assign fy = s1_ychk_reg && ydata[mggeb_pkg::NODE_W];
    assign fz = s1_zchk_reg && zdata[mggeb_pkg::NODE_W];

    assign push = s1_valid_reg && s1_set_reg;

    always_comb
    begin
        push_item.node  = s1_node_reg;
        push_item.vidx  = s1_vidx_reg;
        push_item.nb0   = fx ? s1_xnode_reg
                        : (fy ? ydata[mggeb_pkg::NODE_W-1:0] : zdata[mggeb_pkg::NODE_W-1:0]);
        push_item.nb1   = (fx && fy) ? ydata[mggeb_pkg::NODE_W-1:0]
                                     : zdata[mggeb_pkg::NODE_W-1:0];
        push_item.nb2   = zdata[mggeb_pkg::NODE_W-1:0];
        push_item.edges = mggeb_pkg::SUB_W'(fx) + mggeb_pkg::SUB_W'(fy)
                        + mggeb_pkg::SUB_W'(fz);
    end

endmodule

[src/mggeb_queue.sv]
// Short queue of packed voxel items between the front and back ends.
module mggeb_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mggeb_pkg::item_t         push_item,
    input  logic                     pop,
    output mggeb_pkg::item_t         head,
    output mggeb_pkg::queue_status_t status
);

    mggeb_pkg::item_t              q_mem [mggeb_pkg::QDEPTH];
    logic [mggeb_pkg::Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mggeb_pkg::Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mggeb_pkg::Q_CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mggeb_pkg::Q_AW'(mggeb_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + mggeb_pkg::Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mggeb_pkg::Q_AW'(mggeb_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + mggeb_pkg::Q_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + mggeb_pkg::Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - mggeb_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = q_mem[rd_ptr_reg];
    assign status.empty = count_reg == '0;
    assign status.count = count_reg;

endmodule

[src/mggeb_back.sv]
// Back end: expands each queued voxel into its node record and edges.
module mggeb_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mggeb_pkg::item_t             head,
    input  mggeb_pkg::queue_status_t     status,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         kind,
    output logic [mggeb_pkg::NODE_W-1:0] node_first,
    output logic [mggeb_pkg::NODE_W-1:0] node_second,
    output logic [mggeb_pkg::VOX_W-1:0]  voxel_index,
    output logic                         last
);

    logic [mggeb_pkg::SUB_W-1:0]  sub_reg, sub_next;
    logic                         out_valid_reg, out_valid_next;
    mggeb_pkg::kind_t             kind_reg;
    logic [mggeb_pkg::NODE_W-1:0] first_reg, second_reg;
    logic [mggeb_pkg::VOX_W-1:0]  vidx_reg;
    logic                         last_reg;
    logic                         load;
    logic                         is_last;
    logic [mggeb_pkg::NODE_W-1:0] nb_sel;

    assign load    = !status.empty && (!out_valid_reg || !result_stall);
    assign is_last = sub_reg == head.edges;
    assign pop     = load && is_last;

    always_comb
    begin
        case (sub_reg)
            mggeb_pkg::SUB_W'(1): nb_sel = head.nb0;
            mggeb_pkg::SUB_W'(2): nb_sel = head.nb1;
            default:              nb_sel = head.nb2;
        endcase
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            sub_next       = is_last ? '0 : sub_reg + mggeb_pkg::SUB_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= is_last;
            if (sub_reg == '0)
            begin
                kind_reg   <= mggeb_pkg::KIND_NODE;
                first_reg  <= head.node;
                second_reg <= '0;
                vidx_reg   <= head.vidx;
            end
            else
            begin
                kind_reg   <= mggeb_pkg::KIND_EDGE;
                first_reg  <= nb_sel;
                second_reg <= head.node;
                vidx_reg   <= '0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign node_first   = first_reg;
    assign node_second  = second_reg;
    assign voxel_index  = vidx_reg;
    assign last         = last_reg;

endmodule

[src/masked_grid_graph_edge_builder_unit.sv]
// Top level of the masked grid graph edge builder.
//
//  channel | direction | handshake           | payload
//  mask    | in        | mask_valid/stall    | mask_bit
//  result  | out       | result_valid/stall  | kind, node_first, node_second,
//          |           |                     | voxel_index, last
//  cfg     | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// A voxel is taken every cycle unless mask_stall is high; a set voxel then yields
// its node record and an edge per set x-1, y-1, z-1 neighbor, one result per cycle
// unless result_stall is high, and the four-entry queue absorbs bursts. Reset sets
// all sizes to 256 and the counters to zero; the plane store is not cleared and
// only its entries written earlier in the volume are used. A stall on the result
// side fills the queue and then stalls the mask side.
module masked_grid_graph_edge_builder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           mask_valid,
    output logic                           mask_stall,
    input  logic                           mask_bit,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           kind,
    output logic [mggeb_pkg::NODE_W-1:0]   node_first,
    output logic [mggeb_pkg::NODE_W-1:0]   node_second,
    output logic [mggeb_pkg::VOX_W-1:0]    voxel_index,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mggeb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mggeb_pkg::SIZE_W-1:0]   cfg_data
);

    mggeb_pkg::queue_status_t q_status;
    mggeb_pkg::item_t         push_item;
    mggeb_pkg::item_t         head;
    logic                     push;
    logic                     pop;

    mggeb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mask_valid (mask_valid),
        .mask_stall (mask_stall),
        .mask_bit   (mask_bit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    mggeb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    mggeb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .node_first   (node_first),
        .node_second  (node_second),
        .voxel_index  (voxel_index),
        .last         (last)
    );

    // Every set voxel reaches the queue the cycle after its transfer.
    a_set_voxel_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_valid && !mask_stall && mask_bit) |=> push)
        else $error("set voxel did not reach the queue");

    // The intake credit check must keep the queue from overflowing.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.count == mggeb_pkg::Q_CW'(mggeb_pkg::QDEPTH)) |-> !(push && !pop))
        else $error("queue overflow");

    // Results of one voxel leave back to back once the first has been taken.
    a_edges_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !last)
        |=> (result_valid && kind == mggeb_pkg::KIND_EDGE))
        else $error("edge result missing after non-final result");

endmodule
